// File: design/pawu_pkg.sv
// ----------------------------------------------------------------------------
// pawu_pkg
// Shared types and constants of the piecewise affine warp unit: table sizes,
// field widths, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pawu_pkg;

	localparam int MAX_TRIANGLES = 128;
	localparam int MAX_LANDMARKS = 128;

	localparam int INV_PER_TRI = 9;
	localparam int VTX_PER_TRI = 3;
	localparam int WRP_PER_TRI = 6;

	localparam int INV_DEPTH = MAX_TRIANGLES * INV_PER_TRI;
	localparam int VTX_DEPTH = MAX_TRIANGLES * VTX_PER_TRI;
	localparam int TGT_DEPTH = MAX_LANDMARKS;
	localparam int WRP_DEPTH = MAX_TRIANGLES * WRP_PER_TRI;

	localparam int INV_AW = $clog2(INV_DEPTH);
	localparam int VTX_AW = $clog2(VTX_DEPTH);
	localparam int TGT_AW = $clog2(TGT_DEPTH);
	localparam int WRP_AW = $clog2(WRP_DEPTH);

	localparam int TRI_W  = 7;
	localparam int EL_W   = 4;
	localparam int COEF_W = 32;
	localparam int LM_W   = 7;
	localparam int CRD_W  = 24;
	localparam int WARP_W = 32;
	localparam int PNT_W  = CRD_W + 1;
	localparam int PROD_W = 64;
	localparam int ACC_W  = 60;

	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 240;
	localparam int OUT_USER_W = 1;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic [2:0] {
		MODE_LOAD_INV = 3'd0,
		MODE_LOAD_VTX = 3'd1,
		MODE_LOAD_LM  = 3'd2,
		MODE_SET      = 3'd3,
		MODE_COMPOSE  = 3'd4,
		MODE_MAP      = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		OP_FRESH   = 2'd0,
		OP_COMPOSE = 2'd1,
		OP_MAP     = 2'd2
	} mac_op_t;

	// One multiply-accumulate issue; travels down the pipeline as its tag.
	typedef struct packed {
		logic       valid;
		logic       last;
		mac_op_t    op;
		logic       r;
		logic [1:0] c;
		logic [1:0] k;
	} mac_tag_t;

	typedef struct packed {
		logic       accept;
		logic       load;
		logic       gather;
		logic [3:0] step;
		mac_tag_t   issue;
		logic       wr_valid;
		logic [2:0] wr_idx;
		logic       load_out;
	} pawu_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  tri_ok;
		logic  pipe_busy;
		logic  out_free;
	} pawu_status_t;

endpackage

// File: design/piecewise_affine_warp_unit.sv
// ----------------------------------------------------------------------------
// piecewise_affine_warp_unit
// Piecewise affine warp engine for a triangle mesh: table loads, affine set
// and compose per triangle, and mapping of raster pixels.
// ----------------------------------------------------------------------------
// Words enter on the s_axis channel (command in tuser) and one result word
// leaves on m_axis for every word accepted. shape_min_x and shape_min_y sit
// at APB addresses 0 and 4; write them only while the unit is idle.
// One word is worked at a time; s_axis_tready is high only between words.
// Set, compose and map words pass through the shared 32 x 32 multiplier,
// which takes one product a cycle (18 for each fresh or composed affine, 6
// for a map), the accumulate pipeline behind it and the single-port table
// reads of the gather phase. The next word can be taken in the cycle after
// the result enters the output register.
// If the receiver stalls, the result waits in the output register and a
// following word is still taken and worked; it holds in its result phase
// until the register frees. Reset empties the output register, returns the
// sequencer to idle and clears both configuration registers; the tables
// are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module piecewise_affine_warp_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// fields from the lowest bit: triangle, element, coeff_value, landmark,
	// coord_x, coord_y, zero padding
	input  logic [pawu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// fields from the lowest bit: mode
	input  logic [pawu_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// fields from the lowest bit: warp_a, warp_b, warp_c, warp_d, warp_e,
	// warp_f, mapped_x, mapped_y
	output logic [pawu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// fields from the lowest bit: status
	output logic [pawu_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pawu_pkg::APB_AW-1:0]     paddr,
	input  logic [pawu_pkg::APB_DW-1:0]     pwdata,
	output logic [pawu_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);
	import pawu_pkg::*;

	pawu_cmd_t    cmd;
	pawu_status_t status;

	pawu_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	pawu_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

// File: design/pawu_ctrl.sv
// ----------------------------------------------------------------------------
// pawu_ctrl
// Sequencer of the warp unit: accepts a word, walks the load or the gather,
// multiply and write-back phases and hands the result to the output register.
// ----------------------------------------------------------------------------
module pawu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  pawu_pkg::pawu_status_t status,
	output pawu_pkg::pawu_cmd_t    cmd
);
	import pawu_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_DISPATCH = 9'b000000010,
		ST_LOAD     = 9'b000000100,
		ST_GATHER   = 9'b000001000,
		ST_FRESH    = 9'b000010000,
		ST_COMPOSE  = 9'b000100000,
		ST_MAP      = 9'b001000000,
		ST_WRITE    = 9'b010000000,
		ST_RESULT   = 9'b100000000
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic       r_q;
	logic [1:0] c_q;
	logic [1:0] k_q;
	logic       issuing_q;
	logic       in_mac;
	logic       is_map;
	logic       final_issue;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_mac = (state_q == ST_FRESH) || (state_q == ST_COMPOSE) || (state_q == ST_MAP);
	assign is_map = (state_q == ST_MAP);
	assign final_issue = r_q && (k_q == 2'd2) && (is_map || (c_q == 2'd2));

	always_comb begin
		cmd = '0;
		cmd.accept = s_axis_tvalid && s_axis_tready;
		cmd.load = (state_q == ST_LOAD);
		cmd.gather = (state_q == ST_GATHER);
		cmd.step = step_q;
		cmd.issue.valid = in_mac && issuing_q;
		cmd.issue.last = (k_q == 2'd2);
		cmd.issue.r = r_q;
		cmd.issue.c = c_q;
		cmd.issue.k = k_q;
		case (state_q)
			ST_COMPOSE: cmd.issue.op = OP_COMPOSE;
			ST_MAP:     cmd.issue.op = OP_MAP;
			default:    cmd.issue.op = OP_FRESH;
		endcase
		cmd.wr_valid = (state_q == ST_WRITE);
		cmd.wr_idx = step_q[2:0];
		cmd.load_out = (state_q == ST_RESULT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			r_q <= 1'b0;
			c_q <= '0;
			k_q <= '0;
			issuing_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept)
						state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					step_q <= '0;
					case (status.mode)
						MODE_LOAD_INV, MODE_LOAD_VTX, MODE_LOAD_LM: state_q <= ST_LOAD;
						MODE_SET, MODE_COMPOSE, MODE_MAP: begin
							state_q <= status.tri_ok ? ST_GATHER : ST_RESULT;
						end
						default: state_q <= ST_RESULT;
					endcase
				end
				ST_LOAD: state_q <= ST_RESULT;
				ST_GATHER: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd9) begin
						state_q <= (status.mode == MODE_MAP) ? ST_MAP : ST_FRESH;
						r_q <= 1'b0;
						c_q <= '0;
						k_q <= '0;
						issuing_q <= 1'b1;
					end
				end
				ST_FRESH, ST_COMPOSE, ST_MAP: begin
					if (issuing_q) begin
						if (final_issue)
							issuing_q <= 1'b0;
						if (k_q != 2'd2) begin
							k_q <= k_q + 2'd1;
						end else begin
							k_q <= '0;
							if (is_map || c_q == 2'd2) begin
								c_q <= '0;
								r_q <= ~r_q;
							end else begin
								c_q <= c_q + 2'd1;
							end
						end
					end else if (!status.pipe_busy) begin
						step_q <= '0;
						if (state_q == ST_FRESH && status.mode == MODE_COMPOSE) begin
							state_q <= ST_COMPOSE;
							r_q <= 1'b0;
							c_q <= '0;
							k_q <= '0;
							issuing_q <= 1'b1;
						end else if (state_q == ST_MAP) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd5)
						state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/pawu_datapath.sv
// ----------------------------------------------------------------------------
// pawu_datapath
// Tables, configuration registers, shared multiply-accumulate pipeline and
// output register of the warp unit, driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module pawu_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	// fields from the lowest bit: triangle, element, coeff_value, landmark,
	// coord_x, coord_y, zero padding
	input  logic [pawu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// fields from the lowest bit: mode
	input  logic [pawu_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// fields from the lowest bit: warp_a, warp_b, warp_c, warp_d, warp_e,
	// warp_f, mapped_x, mapped_y
	output logic [pawu_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// fields from the lowest bit: status
	output logic [pawu_pkg::OUT_USER_W-1:0]    m_axis_tuser,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pawu_pkg::APB_AW-1:0]        paddr,
	input  logic [pawu_pkg::APB_DW-1:0]        pwdata,
	output logic [pawu_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,
	input  pawu_pkg::pawu_cmd_t                cmd,
	output pawu_pkg::pawu_status_t             status
);
	import pawu_pkg::*;

	localparam logic signed [ACC_W-1:0]  RND16 = ACC_W'(1) << 15;
	localparam logic signed [ACC_W-1:0]  RND20 = ACC_W'(1) << 19;
	localparam logic signed [PROD_W-1:0] RND20P = PROD_W'(1) << 19;
	localparam logic signed [WARP_W-1:0] ONE_Q20 = WARP_W'(1) << 20;
	localparam logic signed [WARP_W-1:0] ONE_Q8 = WARP_W'(256);

	function automatic logic [WARP_W:0] sat_warp(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-WARP_W:0] top;
		top = v[ACC_W-1:WARP_W-1];
		if (top == '0 || top == '1)
			return {1'b0, v[WARP_W-1:0]};
		else if (v[ACC_W-1])
			return {2'b11, {(WARP_W-1){1'b0}}};
		else
			return {2'b10, {(WARP_W-1){1'b1}}};
	endfunction

	function automatic logic [CRD_W:0] sat_crd(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-CRD_W:0] top;
		top = v[ACC_W-1:CRD_W-1];
		if (top == '0 || top == '1)
			return {1'b0, v[CRD_W-1:0]};
		else if (v[ACC_W-1])
			return {2'b11, {(CRD_W-1){1'b0}}};
		else
			return {2'b10, {(CRD_W-1){1'b1}}};
	endfunction

	// configuration
	logic signed [CRD_W-1:0] shape_min_x_q;
	logic signed [CRD_W-1:0] shape_min_y_q;

	// latched word
	mode_t                   mode_q;
	logic [TRI_W-1:0]        tri_q;
	logic [EL_W-1:0]         el_q;
	logic signed [COEF_W-1:0] coef_q;
	logic [LM_W-1:0]         lm_q;
	logic signed [CRD_W-1:0] cx_q;
	logic signed [CRD_W-1:0] cy_q;
	logic signed [PNT_W-1:0] x_q;
	logic signed [PNT_W-1:0] y_q;
	logic                    tri_ok;
	logic                    lm_ok;

	// tables
	logic [COEF_W-1:0]  inv_mem [0:INV_DEPTH-1];
	logic [LM_W-1:0]    vtx_mem [0:VTX_DEPTH-1];
	logic [2*CRD_W-1:0] tgt_mem [0:TGT_DEPTH-1];
	logic [WARP_W-1:0]  wrp_mem [0:WRP_DEPTH-1];
	logic [COEF_W-1:0]  inv_rd_q;
	logic [LM_W-1:0]    vtx_rd_q;
	logic [2*CRD_W-1:0] tgt_rd_q;
	logic [WARP_W-1:0]  wrp_rd_q;
	logic [INV_AW-1:0]  inv_addr;
	logic [VTX_AW-1:0]  vtx_addr;
	logic [TGT_AW-1:0]  tgt_addr;
	logic [WRP_AW-1:0]  wrp_addr;
	logic               inv_we, inv_re, vtx_we, vtx_re, tgt_we, tgt_re, wrp_we, wrp_re;
	logic [WARP_W-1:0]  wrp_wdata;

	// gathered operands and results
	logic signed [COEF_W-1:0] inv_q [0:8];
	logic signed [CRD_W-1:0]  px_q [0:2];
	logic signed [CRD_W-1:0]  py_q [0:2];
	logic signed [WARP_W-1:0] s_q [0:5];
	logic signed [WARP_W-1:0] f_q [0:5];
	logic signed [WARP_W-1:0] res_q [0:5];
	logic                     sat_q;

	// multiply-accumulate pipeline
	logic signed [WARP_W-1:0] op_a, op_b;
	logic [3:0]               inv_idx;
	logic [2:0]               row_base;
	logic signed [PROD_W-1:0] prod_c, prod_s1;
	logic signed [ACC_W-1:0]  term_c, term_s2;
	logic signed [ACC_W-1:0]  acc_q;
	mac_tag_t                 tag_s1, tag_s2, tag_s3;
	logic [2:0]               fin_idx;
	logic [WARP_W:0]          fin_fresh, fin_comp;
	logic [CRD_W:0]           fin_map;

	logic                     out_valid_q;
	logic [OUT_DATA_W-1:0]    out_data_q;
	logic [OUT_USER_W-1:0]    out_user_q;

	// APB registers
	assign pready = 1'b1;
	assign prdata = paddr[2] ? APB_DW'(unsigned'(shape_min_y_q))
	                         : APB_DW'(unsigned'(shape_min_x_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_min_x_q <= '0;
			shape_min_y_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2])
				shape_min_y_q <= pwdata[CRD_W-1:0];
			else
				shape_min_x_q <= pwdata[CRD_W-1:0];
		end
	end

	// input word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode_t'(s_axis_tuser);
			tri_q  <= s_axis_tdata[6:0];
			el_q   <= s_axis_tdata[10:7];
			coef_q <= s_axis_tdata[42:11];
			lm_q   <= s_axis_tdata[49:43];
			cx_q   <= s_axis_tdata[73:50];
			cy_q   <= s_axis_tdata[97:74];
			x_q <= PNT_W'($signed(s_axis_tdata[73:50])) + PNT_W'(shape_min_x_q);
			y_q <= PNT_W'($signed(s_axis_tdata[97:74])) + PNT_W'(shape_min_y_q);
		end
	end

	assign tri_ok = int'(tri_q) < MAX_TRIANGLES;
	assign lm_ok = int'(lm_q) < MAX_LANDMARKS;

	// table access
	always_comb begin
		inv_addr = INV_AW'(tri_q) * INV_AW'(INV_PER_TRI)
		         + (cmd.load ? INV_AW'(el_q) : INV_AW'(cmd.step));
		vtx_addr = VTX_AW'(tri_q) * VTX_AW'(VTX_PER_TRI)
		         + (cmd.load ? VTX_AW'(el_q) : VTX_AW'(cmd.step));
		tgt_addr = cmd.load ? TGT_AW'(lm_q) : TGT_AW'(vtx_rd_q);
		wrp_addr = WRP_AW'(tri_q) * WRP_AW'(WRP_PER_TRI)
		         + (cmd.wr_valid ? WRP_AW'(cmd.wr_idx) : WRP_AW'(cmd.step));
		inv_we = cmd.load && mode_q == MODE_LOAD_INV && tri_ok && int'(el_q) < INV_PER_TRI;
		vtx_we = cmd.load && mode_q == MODE_LOAD_VTX && tri_ok && lm_ok
		      && int'(el_q) < VTX_PER_TRI;
		tgt_we = cmd.load && mode_q == MODE_LOAD_LM && lm_ok;
		wrp_we = cmd.wr_valid;
		inv_re = cmd.gather && int'(cmd.step) < INV_PER_TRI;
		vtx_re = cmd.gather && int'(cmd.step) < VTX_PER_TRI;
		tgt_re = cmd.gather && cmd.step >= 4'd1 && cmd.step <= 4'd3;
		wrp_re = cmd.gather && int'(cmd.step) < WRP_PER_TRI;
		wrp_wdata = (mode_q == MODE_SET) ? f_q[cmd.wr_idx] : res_q[cmd.wr_idx];
	end

	always_ff @(posedge clk) begin
		if (inv_we)
			inv_mem[inv_addr] <= coef_q;
		if (inv_re)
			inv_rd_q <= inv_mem[inv_addr];
	end

	always_ff @(posedge clk) begin
		if (vtx_we)
			vtx_mem[vtx_addr] <= lm_q;
		if (vtx_re)
			vtx_rd_q <= vtx_mem[vtx_addr];
	end

	always_ff @(posedge clk) begin
		if (tgt_we)
			tgt_mem[tgt_addr] <= {cy_q, cx_q};
		if (tgt_re)
			tgt_rd_q <= tgt_mem[tgt_addr];
	end

	always_ff @(posedge clk) begin
		if (wrp_we)
			wrp_mem[wrp_addr] <= wrp_wdata;
		if (wrp_re)
			wrp_rd_q <= wrp_mem[wrp_addr];
	end

	// Read data are registered and arrive in the cycle after their address, and
	// the landmark reads trail the vertex reads by a further register.
	always_ff @(posedge clk) begin
		if (cmd.gather) begin
			if (cmd.step >= 4'd1 && cmd.step <= 4'd9)
				inv_q[cmd.step - 4'd1] <= inv_rd_q;
			if (cmd.step >= 4'd1 && cmd.step <= 4'd6)
				s_q[3'(cmd.step - 4'd1)] <= wrp_rd_q;
			if (cmd.step >= 4'd2 && cmd.step <= 4'd4) begin
				px_q[2'(cmd.step - 4'd2)] <= tgt_rd_q[CRD_W-1:0];
				py_q[2'(cmd.step - 4'd2)] <= tgt_rd_q[2*CRD_W-1:CRD_W];
			end
		end
	end

	// Every output is the sum of three products. Compose adds the fresh
	// translation as a product with one in Q12.20, map the stored one as a
	// product with one in Q24.8.
	always_comb begin
		inv_idx = 4'(cmd.issue.c) * 4'd3 + 4'(cmd.issue.k);
		row_base = cmd.issue.r ? 3'd3 : 3'd0;
		op_a = '0;
		op_b = '0;
		case (cmd.issue.op)
			OP_FRESH: begin
				op_a = inv_q[inv_idx];
				op_b = cmd.issue.r ? WARP_W'(py_q[cmd.issue.k]) : WARP_W'(px_q[cmd.issue.k]);
			end
			OP_COMPOSE: begin
				op_a = f_q[row_base + 3'(cmd.issue.k)];
				case (cmd.issue.k)
					2'd0:    op_b = s_q[3'(cmd.issue.c)];
					2'd1:    op_b = s_q[3'(cmd.issue.c) + 3'd3];
					default: op_b = (cmd.issue.c == 2'd2) ? ONE_Q20 : '0;
				endcase
			end
			OP_MAP: begin
				op_a = s_q[row_base + 3'(cmd.issue.k)];
				case (cmd.issue.k)
					2'd0:    op_b = WARP_W'(x_q);
					2'd1:    op_b = WARP_W'(y_q);
					default: op_b = ONE_Q8;
				endcase
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod_c = op_a * op_b;
	end

	assign term_c = (tag_s1.op == OP_COMPOSE) ? ACC_W'((prod_s1 + RND20P) >>> 20)
	                                          : ACC_W'(prod_s1);
	assign fin_idx = (tag_s3.r ? 3'd3 : 3'd0) + 3'(tag_s3.c);
	assign fin_fresh = sat_warp((acc_q + RND16) >>> 16);
	assign fin_comp = sat_warp(acc_q);
	assign fin_map = sat_crd((acc_q + RND20) >>> 20);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= cmd.issue;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		term_s2 <= term_c;
		if (tag_s2.valid)
			acc_q <= (tag_s2.k == 2'd0) ? term_s2 : acc_q + term_s2;
		if (cmd.accept) begin
			sat_q <= 1'b0;
		end else if (tag_s3.valid && tag_s3.last) begin
			case (tag_s3.op)
				OP_FRESH: begin
					f_q[fin_idx] <= fin_fresh[WARP_W-1:0];
					sat_q <= sat_q | fin_fresh[WARP_W];
				end
				OP_COMPOSE: begin
					res_q[fin_idx] <= fin_comp[WARP_W-1:0];
					sat_q <= sat_q | fin_comp[WARP_W];
				end
				OP_MAP: begin
					res_q[3'(tag_s3.r)] <= WARP_W'($signed(fin_map[CRD_W-1:0]));
					sat_q <= sat_q | fin_map[CRD_W];
				end
				default: sat_q <= sat_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= '0;
			out_user_q <= '0;
			if (tri_ok) begin
				case (mode_q)
					MODE_SET: begin
						out_data_q[191:0] <= {f_q[5], f_q[4], f_q[3], f_q[2], f_q[1], f_q[0]};
						out_user_q <= sat_q;
					end
					MODE_COMPOSE: begin
						out_data_q[191:0] <= {res_q[5], res_q[4], res_q[3],
						                      res_q[2], res_q[1], res_q[0]};
						out_user_q <= sat_q;
					end
					MODE_MAP: begin
						out_data_q[239:192] <= {res_q[1][CRD_W-1:0], res_q[0][CRD_W-1:0]};
						out_user_q <= sat_q;
					end
					default: out_user_q <= '0;
				endcase
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_user_q;

	assign status.mode = mode_q;
	assign status.tri_ok = tri_ok;
	assign status.pipe_busy = tag_s1.valid || tag_s2.valid || tag_s3.valid;
	assign status.out_free = !out_valid_q || m_axis_tready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_axis_tready))
		else $error("result word overwritten before it was taken");

	a_write_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_valid |-> !(tag_s1.valid || tag_s2.valid || tag_s3.valid))
		else $error("warp table written while products are in flight");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(tag_s1.valid || tag_s2.valid || tag_s3.valid || cmd.gather))
		else $error("word accepted while the previous one is still in work");

	a_gather_before_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue.valid && !tag_s1.valid && !tag_s2.valid && !tag_s3.valid
		 && cmd.issue.k == 2'd0 && cmd.issue.c == 2'd0 && !cmd.issue.r
		 && cmd.issue.op != OP_COMPOSE) |-> $past(cmd.gather))
		else $error("multiply pass started without a gather");

endmodule
